// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general clocked property, off during reset
`define E2C_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication, off during reset
`define E2C_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/e2c_pkg.sv -----
// constants and helper functions for the epoch seconds to calendar converter
package e2c_pkg;

  // seconds per day split as 2^7 * 675; quotient by reciprocal 2^35 / 675
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam int unsigned DAY_SHIFT     = 35;
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

  // days / 365 by reciprocal 2^25 / 365
  localparam int unsigned YEAR_SHIFT    = 25;
  localparam logic [16:0] YEAR_RECIP    = 17'd91930;
  localparam logic [16:0] DAYS_PER_YEAR = 17'd365;

  // (days + 4) / 7 by reciprocal 2^19 / 7
  localparam int unsigned WEEK_SHIFT    = 19;
  localparam logic [16:0] WEEK_RECIP    = 17'd74899;
  localparam logic [15:0] DAYS_PER_WEEK = 16'd7;
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;

  // seconds of day / 3600 by reciprocal 2^30 / 3600
  localparam int unsigned HOUR_SHIFT    = 30;
  localparam logic [18:0] HOUR_RECIP    = 19'd298262;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;

  // seconds of hour / 60 by reciprocal 2^18 / 60
  localparam int unsigned MIN_SHIFT     = 18;
  localparam logic [12:0] MIN_RECIP     = 13'd4370;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;

  // 1970 - 1900
  localparam logic [7:0] YEAR_OFFSET    = 8'd70;
  // 2100 - 1970, the one century year in range that is not leap
  localparam logic [7:0] YEAR_2100      = 8'd130;
  // multiples of four up to 1969
  localparam logic [11:0] QUADS_TO_1969 = 12'd492;
  localparam logic [11:0] YEAR_1969     = 12'd1969;
  localparam logic [11:0] YEAR_2099     = 12'd2099;
  localparam int unsigned LAST_MONTH    = 11;

  // leap days in years 1970 .. 1970 + yoff - 1
  function automatic logic [5:0] leaps_before(input logic [7:0] yoff);
    logic [11:0] last;
    logic [11:0] quads;
    last  = YEAR_1969 + 12'(yoff);
    quads = (last >> 2) - QUADS_TO_1969;
    if (last > YEAR_2099) begin
      quads = quads - 12'd1;
    end
    return quads[5:0];
  endfunction

  // leap flag of year 1970 + yoff
  function automatic logic is_leap(input logic [7:0] yoff);
    logic [7:0] sum;
    sum = yoff + 8'd2;
    return (sum[1:0] == 2'd0) && (yoff != YEAR_2100);
  endfunction

  // day of year at which the month after month m starts, non-leap
  function automatic logic [8:0] month_end(input logic [3:0] m);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd31;
      4'd1:    v = 9'd59;
      4'd2:    v = 9'd90;
      4'd3:    v = 9'd120;
      4'd4:    v = 9'd151;
      4'd5:    v = 9'd181;
      4'd6:    v = 9'd212;
      4'd7:    v = 9'd243;
      4'd8:    v = 9'd273;
      4'd9:    v = 9'd304;
      4'd10:   v = 9'd334;
      default: v = 9'd365;
    endcase
    return v;
  endfunction

  // first zero-based day of year of month m
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      default: v = 9'd334;
    endcase
    if (leap && (m >= 4'd2)) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

endpackage

// ----- hdl/epoch_seconds_to_calendar.sv -----
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into time of day
// and Gregorian date. Six register stages: a word accepted into stage 1 passes through stages
// 2 to 5 into the output register, and one word is accepted every cycle while the output
// is taken. Stage depth is set by the constant-reciprocal multipliers (divide by 86400, 365,
// 7, 3600 and 60), at most one multiply deep per stage. Each stage holds its word until the
// next stage has room, so bubbles close up and a stalled output still lets the earlier
// stages fill.
module epoch_seconds_to_calendar
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_index,
  output logic [7:0]  years_since_1900,
  output logic [2:0]  weekday,
  output logic [8:0]  day_of_year
);

  // stage enables
  logic en1, en2, en3, en4, en5, en6;

  // stage 1: days since epoch
  logic        s1_vld;
  logic [15:0] s1_days;
  logic [16:0] s1_low;
  logic [50:0] day_prod;

  // stage 2: seconds of day, year estimate, week quotient
  logic        s2_vld;
  logic [15:0] s2_days;
  logic [16:0] s2_rem;
  logic [7:0]  s2_yoff;
  logic [15:0] s2_wv;
  logic [13:0] s2_q7;
  logic [32:0] dsec_prod;
  logic [32:0] year_prod;
  logic [32:0] week_prod;
  logic [15:0] wv;

  // stage 3: days before estimated year, hour, weekday
  logic        s3_vld;
  logic [15:0] s3_days;
  logic [16:0] s3_base;
  logic [7:0]  s3_yoff;
  logic [4:0]  s3_hour;
  logic [16:0] s3_rem;
  logic [2:0]  s3_wday;
  logic [35:0] hour_prod;
  logic [15:0] wdiff;

  // stage 4: corrected year and day of year
  logic        s4_vld;
  logic [8:0]  s4_yday;
  logic [7:0]  s4_year;
  logic        s4_leap;
  logic [4:0]  s4_hour;
  logic [11:0] s4_rem;
  logic [2:0]  s4_wday;
  logic signed [17:0] dd;
  logic signed [17:0] dfix;
  logic [7:0]  yfin;
  logic        lfin;
  logic [16:0] hsec;

  // stage 5: month and minute
  logic        s5_vld;
  logic [8:0]  s5_yday;
  logic [3:0]  s5_month;
  logic        s5_leap;
  logic [7:0]  s5_year;
  logic [4:0]  s5_hour;
  logic [5:0]  s5_min;
  logic [11:0] s5_rem;
  logic [2:0]  s5_wday;
  logic [3:0]  mcount;
  logic [24:0] min_prod;

  // stage 6 combinational
  logic [11:0] sec_full;
  logic [8:0]  dom_full;

  assign en6 = !out_valid || !out_stall;
  assign en5 = !s5_vld || en6;
  assign en4 = !s4_vld || en5;
  assign en3 = !s3_vld || en4;
  assign en2 = !s2_vld || en3;
  assign en1 = !s1_vld || en2;
  assign in_stall = !en1;

  // stage 1
  assign day_prod = 51'(epoch_seconds[31:DAY_PRE_SHIFT]) * 51'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en1) begin
      s1_vld <= in_valid;
    end
    if (en1) begin
      s1_days <= day_prod[DAY_SHIFT +: 16];
      s1_low  <= epoch_seconds[16:0];
    end
  end

  // stage 2
  assign dsec_prod = 33'(s1_days) * 33'(SECS_PER_DAY);
  assign year_prod = 33'(s1_days) * 33'(YEAR_RECIP);
  assign wv        = s1_days + EPOCH_WEEKDAY;
  assign week_prod = 33'(wv) * 33'(WEEK_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en2) begin
      s2_vld <= s1_vld;
    end
    if (en2) begin
      s2_days <= s1_days;
      s2_rem  <= s1_low - dsec_prod[16:0];
      s2_yoff <= year_prod[YEAR_SHIFT +: 8];
      s2_wv   <= wv;
      s2_q7   <= week_prod[WEEK_SHIFT +: 14];
    end
  end

  // stage 3
  assign hour_prod = 36'(s2_rem) * 36'(HOUR_RECIP);
  assign wdiff     = s2_wv - 16'(16'(s2_q7) * DAYS_PER_WEEK);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en3) begin
      s3_vld <= s2_vld;
    end
    if (en3) begin
      s3_days <= s2_days;
      s3_base <= 17'(17'(s2_yoff) * DAYS_PER_YEAR) + 17'(leaps_before(s2_yoff));
      s3_yoff <= s2_yoff;
      s3_hour <= hour_prod[HOUR_SHIFT +: 5];
      s3_rem  <= s2_rem;
      s3_wday <= wdiff[2:0];
    end
  end

  // stage 4
  assign dd   = $signed({2'b00, s3_days}) - $signed({1'b0, s3_base});
  assign yfin = dd[17] ? (s3_yoff - 8'd1) : s3_yoff;
  assign lfin = is_leap(yfin);
  assign dfix = dd[17] ? (dd + $signed(18'(DAYS_PER_YEAR)) + $signed({17'd0, lfin})) : dd;
  assign hsec = 17'(17'(s3_hour) * SECS_PER_HOUR);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en4) begin
      s4_vld <= s3_vld;
    end
    if (en4) begin
      s4_yday <= dfix[8:0];
      s4_year <= yfin;
      s4_leap <= lfin;
      s4_hour <= s3_hour;
      s4_rem  <= 12'(s3_rem - hsec);
      s4_wday <= s3_wday;
    end
  end

  // stage 5: month is the count of month ends already passed
  always_comb begin
    mcount = 4'd0;
    for (int k = 0; k < LAST_MONTH; k++) begin
      if (s4_yday >= (month_end(4'(k)) + 9'((k >= 1) && s4_leap))) begin
        mcount = mcount + 4'd1;
      end
    end
  end

  assign min_prod = 25'(s4_rem) * 25'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en5) begin
      s5_vld <= s4_vld;
    end
    if (en5) begin
      s5_yday  <= s4_yday;
      s5_month <= mcount;
      s5_leap  <= s4_leap;
      s5_year  <= s4_year;
      s5_hour  <= s4_hour;
      s5_min   <= min_prod[MIN_SHIFT +: 6];
      s5_rem   <= s4_rem;
      s5_wday  <= s4_wday;
    end
  end

  // stage 6: output register
  assign sec_full = s5_rem - 12'(12'(s5_min) * SECS_PER_MIN);
  assign dom_full = s5_yday - month_start(s5_month, s5_leap) + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en6) begin
      out_valid <= s5_vld;
    end
    if (en6) begin
      second           <= sec_full[5:0];
      minute           <= s5_min;
      hour             <= s5_hour;
      day_of_month     <= dom_full[4:0];
      month_index      <= s5_month;
      years_since_1900 <= s5_year + YEAR_OFFSET;
      weekday          <= s5_wday;
      day_of_year      <= s5_yday + 9'd1;
    end
  end

endmodule

// ----- hdl/e2c_check.sv -----
// port-level checker for the epoch seconds to calendar converter, with its bind
`include "assert_macros.svh"

module e2c_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] epoch_seconds,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  second,
  input logic [5:0]  minute,
  input logic [4:0]  hour,
  input logic [4:0]  day_of_month,
  input logic [3:0]  month_index,
  input logic [7:0]  years_since_1900,
  input logic [2:0]  weekday,
  input logic [8:0]  day_of_year
);

  logic [45:0] out_word;

  assign out_word = {second, minute, hour, day_of_month, month_index,
                     years_since_1900, weekday, day_of_year};

  // stalled output word holds
  `E2C_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled output word changed")

  // a word taken with no output stall while it passes through is valid at the output
  `E2C_ASSERT(a_latency, (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "output word late")

  // january day of year equals day of month
  `E2C_ASSERT_IMP(a_jan_yday, out_valid && (month_index == 4'd0), day_of_year == 9'(day_of_month), "january day of year wrong")

  // february follows a full january
  `E2C_ASSERT_IMP(a_feb_yday, out_valid && (month_index == 4'd1), day_of_year == (9'(day_of_month) + 9'd31), "february day of year wrong")

endmodule

bind epoch_seconds_to_calendar e2c_check u_e2c_check (.*);

// ----- tb/tb_top.sv -----
// testbench for epoch_seconds_to_calendar: directed table then random words checked against a predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SECS_DAY  = 86400;
  localparam int unsigned SECS_HOUR = 3600;
  localparam int unsigned SECS_MIN  = 60;
  localparam int          EPOCH_YR  = 1970;
  localparam int          YR_BIAS   = 1900;
  localparam longint      MAX_SECS  = 64'd4294967295;
  localparam int          N_DIR     = 22;
  localparam int          N_RAND    = 1928;
  localparam int          IDLE_PCT  = 14;
  localparam int          WD_LIMIT  = 4000;
  localparam int          TAIL      = 24;
  localparam int          SHOW_MAX  = 10;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] mins;
    logic [4:0] hr;
    logic [4:0] mday;
    logic [3:0] mon;
    logic [7:0] yr;
    logic [2:0] wday;
    logic [8:0] yday;
  } cal_t;

  typedef struct packed {
    logic [31:0] secs;
    bit          known;
    cal_t        want;
  } vector_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] epoch_seconds;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day_of_month;
  logic [3:0]  month_index;
  logic [7:0]  years_since_1900;
  logic [2:0]  weekday;
  logic [8:0]  day_of_year;

  epoch_seconds_to_calendar dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .epoch_seconds    (epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .day_of_month     (day_of_month),
    .month_index      (month_index),
    .years_since_1900 (years_since_1900),
    .weekday          (weekday),
    .day_of_year      (day_of_year)
  );

  logic [31:0] stim_secs[$];
  cal_t        stim_dates[$];
  cal_t        calendar_due[$];
  vector_t     directed[N_DIR];

  int feed_idx     = 0;
  int words_seen   = 0;
  int bad_words    = 0;
  int shown        = 0;
  int leap_days    = 0;
  int year_ends    = 0;
  int quiet_cycles = 0;
  bit took_in      = 1'b0;

  function automatic int leaps_upto(input int y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic bit is_leap_yr(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_to_jan1(input int y);
    return (y - EPOCH_YR) * 365 + leaps_upto(y - 1) - leaps_upto(EPOCH_YR - 1);
  endfunction

  function automatic int month_days(input int m, input bit leap);
    int len;
    case (m)
      1:       len = leap ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic cal_t civil_from_epoch(input logic [31:0] t);
    longint unsigned tt;
    longint unsigned dcount;
    longint unsigned rem;
    int   days;
    int   yr;
    int   mo;
    int   len;
    bit   done;
    cal_t c;
    tt     = t;
    dcount = tt / SECS_DAY;
    rem    = tt - dcount * SECS_DAY;
    c.wday = 3'((dcount + 4) % 7);
    days   = int'(dcount);
    yr     = EPOCH_YR + days / 365;
    days   = days - days_to_jan1(yr);
    // estimate at most one year high
    if (days < 0) begin
      yr   = yr - 1;
      days = days + 365 + (is_leap_yr(yr) ? 1 : 0);
    end
    c.yday = 9'(days + 1);
    mo   = 0;
    done = 1'b0;
    while (!done && mo < 11) begin
      len = month_days(mo, is_leap_yr(yr));
      if (days < len) begin
        done = 1'b1;
      end else begin
        days = days - len;
        mo   = mo + 1;
      end
    end
    c.hr   = 5'(rem / SECS_HOUR);
    rem    = rem % SECS_HOUR;
    c.mins = 6'(rem / SECS_MIN);
    c.sec  = 6'(rem % SECS_MIN);
    c.mday = 5'(days + 1);
    c.mon  = 4'(mo);
    c.yr   = 8'(yr - YR_BIAS);
    return c;
  endfunction

  function automatic logic [31:0] random_secs();
    longint v;
    int     y;
    int     pick;
    pick = $urandom_range(0, 99);
    y    = $urandom_range(EPOCH_YR, 2106);
    if (pick < 40) begin
      v = $urandom();
    end else if (pick < 65) begin
      // around new year
      v = longint'(days_to_jan1(y)) * SECS_DAY - 2 * SECS_DAY + $urandom_range(0, 4 * SECS_DAY);
    end else if (pick < 85) begin
      // around end of february
      v = longint'(days_to_jan1(y) + 59 + (is_leap_yr(y) ? 1 : 0)) * SECS_DAY
          - 2 * SECS_DAY + $urandom_range(0, 3 * SECS_DAY);
    end else if (pick < 95) begin
      // hour and minute edges
      v = longint'($urandom() / SECS_HOUR) * SECS_HOUR - 2 + $urandom_range(0, 4);
    end else if (pick < 98) begin
      v = MAX_SECS - $urandom_range(0, 2 * SECS_DAY);
    end else begin
      v = $urandom_range(0, 2 * SECS_DAY);
    end
    if (v < 0 || v > MAX_SECS) begin
      v = $urandom();
    end
    return 32'(v);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stimulus: input side and output stall
  always @(negedge clk) begin
    bit quiet;
    bit drive;
    if (!rst) begin
      quiet = (feed_idx >= 900) && (feed_idx < 1250);
      if (!in_valid || took_in) begin
        drive = (feed_idx < stim_secs.size()) &&
                (quiet || ($urandom_range(0, 99) >= IDLE_PCT));
        in_valid <= drive;
        if (drive) begin
          epoch_seconds <= stim_secs[feed_idx];
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // accept, predict and check
  always @(posedge clk) begin
    cal_t got;
    cal_t want;
    bit   took_out;
    if (!rst) begin
      took_in  = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (took_in) begin
        calendar_due.push_back(stim_dates[feed_idx]);
        feed_idx = feed_idx + 1;
      end
      if (took_out) begin
        got = '{second, minute, hour, day_of_month, month_index,
                years_since_1900, weekday, day_of_year};
        words_seen = words_seen + 1;
        if (calendar_due.size() == 0) begin
          bad_words = bad_words + 1;
          if (shown < SHOW_MAX) begin
            shown = shown + 1;
            $display("unexpected word: %0d:%0d:%0d mday %0d mon %0d yr %0d wday %0d yday %0d",
                     got.hr, got.mins, got.sec, got.mday, got.mon, got.yr, got.wday, got.yday);
          end
        end else begin
          want = calendar_due.pop_front();
          if (want.mon == 4'd1 && want.mday == 5'd29) leap_days = leap_days + 1;
          if (want.mon == 4'd11 && want.mday == 5'd31) year_ends = year_ends + 1;
          if (got.sec !== want.sec || got.mins !== want.mins || got.hr !== want.hr ||
              got.mday !== want.mday || got.mon !== want.mon || got.yr !== want.yr ||
              got.wday !== want.wday || got.yday !== want.yday) begin
            bad_words = bad_words + 1;
            if (shown < SHOW_MAX) begin
              shown = shown + 1;
              $display("mismatch word %0d: exp %0d:%0d:%0d mday %0d mon %0d yr %0d wday %0d yday %0d",
                       words_seen, want.hr, want.mins, want.sec, want.mday, want.mon,
                       want.yr, want.wday, want.yday);
              $display("                  got %0d:%0d:%0d mday %0d mon %0d yr %0d wday %0d yday %0d",
                       got.hr, got.mins, got.sec, got.mday, got.mon, got.yr, got.wday, got.yday);
            end
          end
        end
      end
      if (took_in || took_out) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d still due", WD_LIMIT,
                 calendar_due.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    out_stall     = 1'b0;
    epoch_seconds = 32'd0;

    directed[0]  = '{32'd0,          1'b1, '{6'd0,  6'd0,  5'd0,  5'd1, 4'd0, 8'd70,  3'd4, 9'd1}};
    directed[1]  = '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 5'd1, 4'd0, 8'd70,  3'd4, 9'd1}};
    directed[2]  = '{32'hFFFFFFFF,   1'b1, '{6'd15, 6'd28, 5'd6,  5'd7, 4'd1, 8'd206, 3'd0, 9'd38}};
    directed[3]  = '{32'd86400,      1'b0, '0};
    directed[4]  = '{32'd31535999,   1'b0, '0};
    directed[5]  = '{32'd31536000,   1'b0, '0};
    directed[6]  = '{32'd68169600,   1'b0, '0};
    directed[7]  = '{32'd94608000,   1'b0, '0};
    directed[8]  = '{32'd94694399,   1'b0, '0};
    directed[9]  = '{32'd94694400,   1'b0, '0};
    directed[10] = '{32'd951782400,  1'b0, '0};
    directed[11] = '{32'd978220800,  1'b0, '0};
    directed[12] = '{32'd978307200,  1'b0, '0};
    directed[13] = '{32'd4102444799, 1'b0, '0};
    directed[14] = '{32'd4102444800, 1'b0, '0};
    directed[15] = '{32'd4107456000, 1'b0, '0};
    directed[16] = '{32'd4107542400, 1'b0, '0};
    directed[17] = '{32'h7FFFFFFF,   1'b0, '0};
    directed[18] = '{32'h80000000,   1'b0, '0};
    directed[19] = '{32'hAAAAAAAA,   1'b0, '0};
    directed[20] = '{32'h55555555,   1'b0, '0};
    directed[21] = '{32'd4294944000, 1'b0, '0};

    for (int i = 0; i < N_DIR; i++) begin
      stim_secs.push_back(directed[i].secs);
      stim_dates.push_back(directed[i].known ? directed[i].want
                                             : civil_from_epoch(directed[i].secs));
    end
    for (int i = 0; i < N_RAND; i++) begin
      stim_secs.push_back(random_secs());
      stim_dates.push_back(civil_from_epoch(stim_secs[stim_secs.size() - 1]));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (feed_idx < stim_secs.size() || calendar_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL) @(posedge clk);

    $display("converted %0d words: %0d from the table, %0d random", words_seen, N_DIR, N_RAND);
    $display("dates hit: %0d leap days, %0d december 31sts; %0d bad words",
             leap_days, year_ends, bad_words);
    if (bad_words == 0 && calendar_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
